// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the dense layer and divider modules of the dense layer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DLF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Check a property on every clock edge, reset included.
`define DLF_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("%m: check failed");
`else
`define DLF_ASSERT(name, prop)
`define DLF_ASSERT_RST(name, prop)
`endif
`endif

// ===== rtl/dlf_pkg.sv =====
// Types and constants of the dense layer block.
package dlf_pkg;

  // Field widths of the channels and the configuration port
  localparam int DATA_W      = 16;
  localparam int OP_W        = 2;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 9;
  localparam int UNIT_W      = 6;
  localparam int ACT_W       = 16;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_COUNT_W  = 9;
  localparam int OUT_COUNT_W = 7;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Fixed point constants
  localparam int Z_FRAC     = 12;
  localparam int EXP_W      = 28;
  localparam int LOG2E_Q12  = 5909;
  localparam int EXP_C1     = 43024;
  localparam int EXP_C2     = 22512;
  localparam int ONE_Q16    = 65536;
  localparam int Q_W        = 16;
  localparam int DIV_NUM_W  = EXP_W + Q_W;
  localparam logic [63:0] SIG_NUM = 64'h1_0000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_WEIGHT = 2'd0,
    OP_LOAD_INPUT   = 2'd1,
    OP_RUN          = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_COUNT  = 2'd0,
    REG_OUT_COUNT = 2'd1,
    REG_ACT_MODE  = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_ZQ,
    ST_EX_A,
    ST_EX_B,
    ST_EX_C,
    ST_EX_D,
    ST_EX_E,
    ST_POST,
    ST_SM_RD,
    ST_SM_LD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/dense_layer_forward.sv =====
// Fully connected layer with sigmoid or softmax output, one shared multiplier and divider.
//
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o | opcode_i, row_i, column_i, value_i
//  out     | out       | out_valid_o/out_ready_i | unit_index_o, activation_o, last_o
//
// A sigmoid run divides each unit right after its dot product and exponential; a
// softmax run does all dot products and exponentials first, then the divisions per
// unit. The dot product walks one element per cycle through the weight and input RAM
// read ports and the shared multiplier; the divider retires one quotient bit per cycle.
// in_ready_o is high only between runs. Reset clears control state only; stores are
// undefined until written. A stalled output holds the sequencer.
`include "assert_macros.svh"
module dense_layer_forward #(
  parameter int MAX_OUTPUTS = 64,
  parameter int MAX_INPUTS  = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dlf_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dlf_pkg::OP_W-1:0]          opcode_i,
  input  logic [dlf_pkg::ROW_W-1:0]         row_i,
  input  logic [dlf_pkg::COL_W-1:0]         column_i,
  input  logic signed [dlf_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dlf_pkg::UNIT_W-1:0]        unit_index_o,
  output logic [dlf_pkg::ACT_W-1:0]         activation_o,
  output logic                              last_o
);
  import dlf_pkg::*;

  localparam int ROW_STRIDE = MAX_INPUTS + 1;
  localparam int WS_DEPTH   = MAX_OUTPUTS * ROW_STRIDE;
  localparam int WS_AW      = $clog2(WS_DEPTH);
  localparam int IN_AW      = $clog2(ROW_STRIDE);
  localparam int U_W        = $clog2(MAX_OUTPUTS + 1);
  localparam int EX_AW      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int ACC_W      = 2 * DATA_W + $clog2(MAX_INPUTS + 1) + 1;
  localparam int SUM_W      = EXP_W + $clog2(MAX_OUTPUTS + 1);

  // Configuration registers
  logic [IN_COUNT_W-1:0]  in_count_q;
  logic [OUT_COUNT_W-1:0] out_count_q;
  logic                   act_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= IN_COUNT_W'(1);
      out_count_q <= OUT_COUNT_W'(1);
      act_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_COUNT:  in_count_q  <= cfg_data_i[IN_COUNT_W-1:0];
        REG_OUT_COUNT: out_count_q <= cfg_data_i[OUT_COUNT_W-1:0];
        REG_ACT_MODE:  act_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_e               state_q, state_d;
  logic                 iss_q, iss_d;
  logic                 p1_q, p1_d;
  logic                 p2_q, p2_d;
  logic [IN_AW-1:0]     v_q, v_d;
  logic [IN_AW-1:0]     ni_q, ni_d;
  logic [U_W-1:0]       u_q, u_d;
  logic [U_W-1:0]       no_q, no_d;
  logic [WS_AW-1:0]     wa_q, wa_d;
  logic [WS_AW-1:0]     base_q, base_d;
  logic                 mode_q, mode_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [DATA_W-1:0] z_q, z_d;
  logic signed [4:0]    n_q, n_d;
  logic [11:0]          f_q, f_d;
  logic [15:0]          lin_q, lin_d;
  logic [EXP_W-1:0]     e_q, e_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic                 out_valid_q, out_valid_d;
  logic [UNIT_W-1:0]    out_unit_q, out_unit_d;
  logic [ACT_W-1:0]     out_act_q, out_act_d;
  logic                 out_last_q, out_last_d;

  // Input side decode
  logic             in_acc;
  logic             ws_we, iv_we;
  logic [WS_AW-1:0] ws_waddr;
  logic [IN_AW-1:0] ni_clamp;
  logic [U_W-1:0]   no_clamp;
  logic             run_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ws_waddr   = WS_AW'(row_i) * WS_AW'(ROW_STRIDE) + WS_AW'(column_i);
  assign ws_we      = in_acc && (opcode_i == OP_WRITE_WEIGHT) &&
                      (int'(row_i) < MAX_OUTPUTS) && (int'(column_i) <= MAX_INPUTS);
  assign iv_we      = in_acc && (opcode_i == OP_LOAD_INPUT) &&
                      (int'(column_i) <= MAX_INPUTS);
  assign ni_clamp   = (int'(in_count_q) > MAX_INPUTS) ? IN_AW'(MAX_INPUTS)
                                                      : IN_AW'(in_count_q);
  assign no_clamp   = (int'(out_count_q) > MAX_OUTPUTS) ? U_W'(MAX_OUTPUTS)
                                                        : U_W'(out_count_q);
  assign run_go     = in_acc && (opcode_i == OP_RUN) && (no_clamp != '0);

  // Stores
  logic [DATA_W-1:0] ws_rdata, iv_rdata;
  logic [EXP_W-1:0]  ex_rdata;
  logic              ex_we;

  dlf_ram #(.WIDTH(DATA_W), .DEPTH(WS_DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ws_we),
    .waddr_i (ws_waddr),
    .wdata_i (value_i),
    .raddr_i (wa_q),
    .rdata_o (ws_rdata)
  );

  dlf_ram #(.WIDTH(DATA_W), .DEPTH(ROW_STRIDE)) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (IN_AW'(column_i)),
    .wdata_i (value_i),
    .raddr_i (v_q),
    .rdata_o (iv_rdata)
  );

  dlf_ram #(.WIDTH(EXP_W), .DEPTH(MAX_OUTPUTS)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (ex_we),
    .waddr_i (u_q[EX_AW-1:0]),
    .wdata_i (e_q),
    .raddr_i (u_q[EX_AW-1:0]),
    .rdata_o (ex_rdata)
  );

  // Shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] p_q;
  logic signed [16:0]        x_arg;

  assign x_arg = mode_q ? 17'(z_q) : -17'(z_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MAC: begin
        mul_a = MUL_A_W'($signed(ws_rdata));
        mul_b = MUL_B_W'($signed(iv_rdata));
      end
      ST_EX_A: begin
        mul_a = MUL_A_W'(x_arg);
        mul_b = MUL_B_W'(LOG2E_Q12);
      end
      ST_EX_B: begin
        mul_a = MUL_A_W'($signed({1'b0, p_q[23:12]}));
        mul_b = MUL_B_W'(EXP_C1);
      end
      ST_EX_C: begin
        mul_a = MUL_A_W'($signed({1'b0, f_q}));
        mul_b = MUL_B_W'($signed({1'b0, f_q}));
      end
      ST_EX_D: begin
        mul_a = $signed({1'b0, p_q[23:0]});
        mul_b = MUL_B_W'(EXP_C2);
      end
      default: ;
    endcase
  end

  dlf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  // Divider operands
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_numer;
  logic [SUM_W-1:0]     div_denom;
  logic [Q_W-1:0]       div_quot;

  assign div_start = ((state_q == ST_POST) && !mode_q) || (state_q == ST_SM_LD);
  assign div_numer = (state_q == ST_SM_LD) ? {ex_rdata, 16'h0} : DIV_NUM_W'(SIG_NUM);
  assign div_denom = (state_q == ST_SM_LD) ? sum_q : SUM_W'(e_q) + SUM_W'(ONE_Q16);

  dlf_div #(.NUM_W(DIV_NUM_W), .DEN_W(SUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Saturate the accumulator to Q4.12
  logic signed [ACC_W-1:0]  q_sh;
  logic signed [DATA_W-1:0] z_clamp;

  assign q_sh = acc_q >>> Z_FRAC;

  always_comb begin
    if (q_sh < -32768) begin
      z_clamp = DATA_W'(-32768);
    end else if (q_sh > 32767) begin
      z_clamp = DATA_W'(32767);
    end else begin
      z_clamp = q_sh[DATA_W-1:0];
    end
  end

  // Assemble the mantissa and apply the power of two
  logic [16:0]      mant;
  logic [4:0]       shr;
  logic [EXP_W-1:0] exp_val;

  assign mant = 17'(ONE_Q16) + 17'(lin_q) + 17'(p_q[38:24]);
  assign shr  = 5'(-n_q);
  assign exp_val = n_q[4] ? (EXP_W'(mant) >> shr) : (EXP_W'(mant) << n_q[3:0]);

  logic last_unit, out_load;

  assign last_unit = (u_q == no_q - 1'b1);
  assign out_load  = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (run_go) state_d = ST_MAC;
      ST_MAC:   if (!iss_q && !p1_q && !p2_q) state_d = ST_ZQ;
      ST_ZQ:    state_d = ST_EX_A;
      ST_EX_A:  state_d = ST_EX_B;
      ST_EX_B:  state_d = ST_EX_C;
      ST_EX_C:  state_d = ST_EX_D;
      ST_EX_D:  state_d = ST_EX_E;
      ST_EX_E:  state_d = ST_POST;
      ST_POST: begin
        if (!mode_q) begin
          state_d = ST_DIV;
        end else if (last_unit) begin
          state_d = ST_SM_RD;
        end else begin
          state_d = ST_MAC;
        end
      end
      ST_SM_RD: state_d = ST_SM_LD;
      ST_SM_LD: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          if (last_unit) begin
            state_d = ST_IDLE;
          end else if (mode_q) begin
            state_d = ST_SM_RD;
          end else begin
            state_d = ST_MAC;
          end
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and output updates
  always_comb begin
    iss_d       = iss_q;
    p1_d        = iss_q;
    p2_d        = p1_q;
    v_d         = v_q;
    ni_d        = ni_q;
    u_d         = u_q;
    no_d        = no_q;
    wa_d        = wa_q;
    base_d      = base_q;
    mode_d      = mode_q;
    acc_d       = acc_q;
    z_d         = z_q;
    n_d         = n_q;
    f_d         = f_q;
    lin_d       = lin_q;
    e_d         = e_q;
    sum_d       = sum_q;
    ex_we       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_unit_d  = out_unit_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (run_go) begin
          ni_d   = ni_clamp;
          no_d   = no_clamp;
          mode_d = act_mode_q;
          u_d    = '0;
          base_d = '0;
          wa_d   = '0;
          v_d    = '0;
          iss_d  = 1'b1;
          acc_d  = '0;
          sum_d  = '0;
        end
      end
      ST_MAC: begin
        // Issue one element per cycle, accumulate once the RAM read and the product are registered
        if (iss_q) begin
          wa_d = wa_q + 1'b1;
          v_d  = v_q + 1'b1;
          if (v_q == ni_q) begin
            iss_d = 1'b0;
          end
        end
        if (p2_q) begin
          acc_d = acc_q + ACC_W'(signed'(p_q[2*DATA_W-1:0]));
        end
      end
      ST_ZQ:   z_d = z_clamp;
      ST_EX_B: begin
        n_d = p_q[28:24];
        f_d = p_q[23:12];
      end
      ST_EX_C: lin_d = p_q[27:12];
      ST_EX_E: e_d = exp_val;
      ST_POST: begin
        if (mode_q) begin
          ex_we = 1'b1;
          sum_d = sum_q + SUM_W'(e_q);
          if (last_unit) begin
            u_d = '0;
          end else begin
            u_d    = u_q + 1'b1;
            base_d = base_q + WS_AW'(ROW_STRIDE);
            wa_d   = base_q + WS_AW'(ROW_STRIDE);
            v_d    = '0;
            iss_d  = 1'b1;
            acc_d  = '0;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_unit_d  = UNIT_W'(u_q);
          out_act_d   = div_quot;
          out_last_d  = last_unit;
          if (!last_unit) begin
            u_d = u_q + 1'b1;
            if (!mode_q) begin
              base_d = base_q + WS_AW'(ROW_STRIDE);
              wa_d   = base_q + WS_AW'(ROW_STRIDE);
              v_d    = '0;
              iss_d  = 1'b1;
              acc_d  = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= 1'b0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    ni_q       <= ni_d;
    u_q        <= u_d;
    no_q       <= no_d;
    wa_q       <= wa_d;
    base_q     <= base_d;
    mode_q     <= mode_d;
    acc_q      <= acc_d;
    z_q        <= z_d;
    n_q        <= n_d;
    f_q        <= f_d;
    lin_q      <= lin_d;
    e_q        <= e_d;
    sum_q      <= sum_d;
    out_unit_q <= out_unit_d;
    out_act_q  <= out_act_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign unit_index_o = out_unit_q;
  assign activation_o = out_act_q;
  assign last_o       = out_last_q;

  `DLF_ASSERT(a_div_done_in_wait, div_done |-> state_q == ST_DIV)
  `DLF_ASSERT(a_run_continues, out_valid_q && !out_last_q |-> state_q != ST_IDLE)
  `DLF_ASSERT(a_issue_bound, iss_q |-> v_q <= ni_q)
  `DLF_ASSERT(a_exp_write_softmax, ex_we |-> mode_q)
  `DLF_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_q)

endmodule

// ===== rtl/dlf_ram.sv =====
// Generic simple dual port RAM with registered read.
module dlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry each cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dlf_mul.sv =====
// Shared signed multiplier with registered product.
module dlf_mul (
  input  logic                                 clk_i,
  input  logic signed [dlf_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [dlf_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [dlf_pkg::MUL_P_W-1:0]   p_o
);
  import dlf_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // Register every product
  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/dlf_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
`include "assert_macros.svh"
module dlf_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 35
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          numer_i,
  input  logic [DEN_W-1:0]          denom_i,
  output logic                      done_o,
  output logic [dlf_pkg::Q_W-1:0]   quot_o
);
  import dlf_pkg::*;

  localparam int W     = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dsh_q, dsh_d;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic             ge;

  assign ge = (rem_q >= dsh_q);

  // Load on start, saturate on overflow, else compare, subtract, shift in a bit
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(Q_W);
      rem_d  = W'(numer_i);
      dsh_d  = W'(denom_i) << Q_W;
      quot_d = '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(Q_W)) begin
        if (ge) begin
          quot_d = '1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          dsh_d = dsh_q >> 1;
          cnt_d = cnt_q - 1'b1;
        end
      end else begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quot_d = {quot_q[Q_W-2:0], ge};
        dsh_d  = dsh_q >> 1;
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `DLF_ASSERT(a_start_when_free, start_i |-> !busy_q)
  `DLF_ASSERT(a_done_single, done_q |=> !done_q)
  `DLF_ASSERT(a_count_bound, busy_q |-> cnt_q <= CNT_W'(Q_W))

endmodule
